>>> sv/kpt_pkg.sv
`timescale 1ns / 1ps

package kpt_pkg;

  // Default table sizes
  localparam int unsigned KEY_COUNT_DEF    = 512;
  localparam int unsigned BUTTON_COUNT_DEF = 16;

  // Field widths fixed by the request and result formats
  localparam int unsigned ACTION_W = 4;
  localparam int unsigned CODE_W   = 9;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned SCROLL_W = 24;

  typedef enum logic [ACTION_W-1:0] {
    ACT_KEY_DOWN    = 4'd0,
    ACT_KEY_UP      = 4'd1,
    ACT_BUTTON_DOWN = 4'd2,
    ACT_BUTTON_UP   = 4'd3,
    ACT_MOTION      = 4'd4,
    ACT_WHEEL       = 4'd5,
    ACT_FRAME_CLEAR = 4'd6,
    ACT_READ_KEY    = 4'd7,
    ACT_READ_BUTTON = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [CODE_W-1:0]         code;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] wheel_x;
    logic signed [COORD_W-1:0] wheel_y;
  } req_t;

  typedef struct packed {
    logic                       entry_down;
    logic [COUNT_W-1:0]         entry_presses;
    logic [COUNT_W-1:0]         entry_releases;
    logic                       code_ignored;
    logic signed [COORD_W-1:0]  pointer_x;
    logic signed [COORD_W-1:0]  pointer_y;
    logic signed [COORD_W-1:0]  pointer_dx;
    logic signed [COORD_W-1:0]  pointer_dy;
    logic signed [SCROLL_W-1:0] scroll_left;
    logic [SCROLL_W-2:0]        scroll_right;
    logic [SCROLL_W-2:0]        scroll_up;
    logic signed [SCROLL_W-1:0] scroll_down;
  } rsp_t;

  // Press and release counters of one table entry
  typedef struct packed {
    logic [COUNT_W-1:0] presses;
    logic [COUNT_W-1:0] releases;
  } entry_cnt_t;

  // Pointer block controls, one strobe per update kind
  typedef struct packed {
    logic load_motion;
    logic add_wheel;
    logic clear_frame;
  } ptr_ctrl_t;

  // Pointer summary
  typedef struct packed {
    logic signed [COORD_W-1:0]  pointer_x;
    logic signed [COORD_W-1:0]  pointer_y;
    logic signed [COORD_W-1:0]  pointer_dx;
    logic signed [COORD_W-1:0]  pointer_dy;
    logic signed [SCROLL_W-1:0] scroll_left;
    logic [SCROLL_W-2:0]        scroll_right;
    logic [SCROLL_W-2:0]        scroll_up;
    logic signed [SCROLL_W-1:0] scroll_down;
  } ptr_sum_t;

endpackage

>>> sv/kpt_stream_if.sv
`timescale 1ns / 1ps

// Request channel
interface kpt_req_if;
  logic          valid;
  logic          ready;
  kpt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface kpt_rsp_if;
  logic          valid;
  logic          ready;
  kpt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/kpt_table.sv
`timescale 1ns / 1ps

// Entry store for keys and buttons: held flags and counter pairs in two
// single-port-write, registered-read memories sharing one address space.
module kpt_table #(
  parameter int unsigned DEPTH = kpt_pkg::KEY_COUNT_DEF + kpt_pkg::BUTTON_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic                held_we_i,
  input  logic                cnt_we_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic                held_wdata_i,
  input  kpt_pkg::entry_cnt_t cnt_wdata_i,
  output logic                held_rdata_o,
  output kpt_pkg::entry_cnt_t cnt_rdata_o
);

  logic                held_mem [DEPTH];
  kpt_pkg::entry_cnt_t cnt_mem  [DEPTH];
  logic                held_rdata_q;
  kpt_pkg::entry_cnt_t cnt_rdata_q;

  // Held flag memory
  always_ff @(posedge clk_i) begin
    if (held_we_i) begin
      held_mem[wr_addr_i] <= held_wdata_i;
    end
    if (rd_en_i) begin
      held_rdata_q <= held_mem[rd_addr_i];
    end
  end

  // Counter memory
  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[wr_addr_i] <= cnt_wdata_i;
    end
    if (rd_en_i) begin
      cnt_rdata_q <= cnt_mem[rd_addr_i];
    end
  end

  assign held_rdata_o = held_rdata_q;
  assign cnt_rdata_o  = cnt_rdata_q;

endmodule

>>> sv/kpt_pointer.sv
`timescale 1ns / 1ps

// Pointer position, last motion and saturating scroll accumulators.
// sum_o shows the state as it stands after the current strobes.
module kpt_pointer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kpt_pkg::ptr_ctrl_t ctrl_i,
  input  kpt_pkg::req_t      item_i,
  output kpt_pkg::ptr_sum_t  sum_o
);

  kpt_pkg::ptr_sum_t sum_q, sum_d;

  logic signed [kpt_pkg::SCROLL_W:0] left_sum, down_sum;
  logic [kpt_pkg::SCROLL_W-1:0]      right_sum, up_sum;
  logic                              wx_neg, wx_pos, wy_neg, wy_pos;

  // Wheel step sign tests
  always_comb begin
    wx_neg = item_i.wheel_x[kpt_pkg::COORD_W-1];
    wy_neg = item_i.wheel_y[kpt_pkg::COORD_W-1];
    wx_pos = !wx_neg && (item_i.wheel_x != '0);
    wy_pos = !wy_neg && (item_i.wheel_y != '0);
  end

  // Raw sums, one bit wider than the accumulators
  always_comb begin
    left_sum  = (kpt_pkg::SCROLL_W+1)'(sum_q.scroll_left)
              + (kpt_pkg::SCROLL_W+1)'(item_i.wheel_x);
    down_sum  = (kpt_pkg::SCROLL_W+1)'(sum_q.scroll_down)
              + (kpt_pkg::SCROLL_W+1)'(item_i.wheel_y);
    right_sum = {1'b0, sum_q.scroll_right}
              + kpt_pkg::SCROLL_W'(item_i.wheel_x[kpt_pkg::COORD_W-2:0]);
    up_sum    = {1'b0, sum_q.scroll_up}
              + kpt_pkg::SCROLL_W'(item_i.wheel_y[kpt_pkg::COORD_W-2:0]);
  end

  // Next state
  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.load_motion) begin
      sum_d.pointer_x  = item_i.pos_x;
      sum_d.pointer_y  = item_i.pos_y;
      sum_d.pointer_dx = item_i.rel_x;
      sum_d.pointer_dy = item_i.rel_y;
    end
    if (ctrl_i.add_wheel) begin
      // negative side saturates when the two top bits disagree
      if (wx_neg) begin
        sum_d.scroll_left = (left_sum[kpt_pkg::SCROLL_W] != left_sum[kpt_pkg::SCROLL_W-1])
                          ? {1'b1, {(kpt_pkg::SCROLL_W-1){1'b0}}}
                          : left_sum[kpt_pkg::SCROLL_W-1:0];
      end else if (wx_pos) begin
        sum_d.scroll_right = right_sum[kpt_pkg::SCROLL_W-1] ? '1
                           : right_sum[kpt_pkg::SCROLL_W-2:0];
      end
      if (wy_pos) begin
        sum_d.scroll_up = up_sum[kpt_pkg::SCROLL_W-1] ? '1
                        : up_sum[kpt_pkg::SCROLL_W-2:0];
      end else if (wy_neg) begin
        sum_d.scroll_down = (down_sum[kpt_pkg::SCROLL_W] != down_sum[kpt_pkg::SCROLL_W-1])
                          ? {1'b1, {(kpt_pkg::SCROLL_W-1){1'b0}}}
                          : down_sum[kpt_pkg::SCROLL_W-1:0];
      end
    end
    if (ctrl_i.clear_frame) begin
      sum_d.pointer_dx   = '0;
      sum_d.pointer_dy   = '0;
      sum_d.scroll_left  = '0;
      sum_d.scroll_right = '0;
      sum_d.scroll_up    = '0;
      sum_d.scroll_down  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_d;

endmodule

>>> sv/key_and_pointer_event_tracker_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload          | Handshake
// req_i   | in  | kpt_pkg::req_t   | valid/ready, taken when both high
// rsp_o   | out | kpt_pkg::rsp_t   | valid/ready, one result per request
//
// Key, button, motion, wheel and read requests read the entry in the accept cycle and write
// it back in the EXEC state, which holds while the result register is still full. A frame
// clear first sweeps the table, zeroing the counter memory one entry per cycle, then goes to EXEC.
// After reset a clearing pass zeroes both memories while req_i.ready stays low. A result waits
// in an output register; a new request is taken meanwhile, and its write-back step holds until
// that register is free.
module key_and_pointer_event_tracker_core #(
  parameter int unsigned KEY_COUNT    = kpt_pkg::KEY_COUNT_DEF,
  parameter int unsigned BUTTON_COUNT = kpt_pkg::BUTTON_COUNT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpt_req_if.sink   req_i,
  kpt_rsp_if.source rsp_o
);

  localparam int unsigned DEPTH = KEY_COUNT + BUTTON_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  // wide enough for codes, addresses and the table sizes
  localparam int unsigned SW    = ((AW > kpt_pkg::CODE_W) ? AW : kpt_pkg::CODE_W) + 1;

  kpt_pkg::state_e state_q, state_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   addr_q;
  kpt_pkg::req_t   item_q;
  kpt_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic                accept, exec_fire, idx_last;
  logic [SW-1:0]       rd_code_ext, code_ext;
  logic                rd_is_button;
  logic [AW-1:0]       rd_addr;
  logic                is_key, is_button, is_down, is_up, hit;
  logic                held_we, cnt_we, held_wdata;
  logic [AW-1:0]       wr_addr;
  kpt_pkg::entry_cnt_t cnt_wdata;
  logic                held_rdata;
  kpt_pkg::entry_cnt_t cnt_rdata;
  logic                held_new;
  kpt_pkg::entry_cnt_t cnt_new;
  kpt_pkg::ptr_ctrl_t  ptr_ctrl;
  kpt_pkg::ptr_sum_t   ptr_sum;

  assign accept    = req_i.valid && req_i.ready;
  assign exec_fire = (state_q == kpt_pkg::ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign idx_last  = (idx_q == AW'(DEPTH - 1));

  // Table address of the incoming request: buttons sit after the keys
  always_comb begin
    rd_code_ext  = SW'(req_i.data.code);
    rd_is_button = req_i.data.action inside {kpt_pkg::ACT_BUTTON_DOWN,
                                             kpt_pkg::ACT_BUTTON_UP,
                                             kpt_pkg::ACT_READ_BUTTON};
    rd_addr      = rd_is_button ? AW'(rd_code_ext + SW'(BUTTON_COUNT - BUTTON_COUNT + KEY_COUNT))
                                : AW'(rd_code_ext);
  end

  // Decode of the request in flight
  always_comb begin
    code_ext  = SW'(item_q.code);
    is_key    = item_q.action inside {kpt_pkg::ACT_KEY_DOWN, kpt_pkg::ACT_KEY_UP,
                                      kpt_pkg::ACT_READ_KEY};
    is_button = item_q.action inside {kpt_pkg::ACT_BUTTON_DOWN, kpt_pkg::ACT_BUTTON_UP,
                                      kpt_pkg::ACT_READ_BUTTON};
    is_down   = item_q.action inside {kpt_pkg::ACT_KEY_DOWN, kpt_pkg::ACT_BUTTON_DOWN};
    is_up     = item_q.action inside {kpt_pkg::ACT_KEY_UP, kpt_pkg::ACT_BUTTON_UP};
    hit       = (is_key && (code_ext < SW'(KEY_COUNT)))
             || (is_button && (code_ext < SW'(BUTTON_COUNT)));
  end

  // Entry update, counters wrap
  always_comb begin
    held_new         = is_down ? 1'b1 : (is_up ? 1'b0 : held_rdata);
    cnt_new.presses  = cnt_rdata.presses + kpt_pkg::COUNT_W'(is_down);
    cnt_new.releases = cnt_rdata.releases + kpt_pkg::COUNT_W'(is_up);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kpt_pkg::ST_INIT: begin
        if (idx_last) state_d = kpt_pkg::ST_IDLE;
      end
      kpt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.data.action == kpt_pkg::ACT_FRAME_CLEAR) ? kpt_pkg::ST_SWEEP
                                                                     : kpt_pkg::ST_EXEC;
        end
      end
      kpt_pkg::ST_SWEEP: begin
        if (idx_last) state_d = kpt_pkg::ST_EXEC;
      end
      kpt_pkg::ST_EXEC: begin
        if (exec_fire) state_d = kpt_pkg::ST_IDLE;
      end
      default: state_d = kpt_pkg::ST_INIT;
    endcase
  end

  // Outputs of the sequencer: memory writes, sweep index, pointer strobes
  always_comb begin
    req_i.ready = (state_q == kpt_pkg::ST_IDLE);
    held_we     = 1'b0;
    cnt_we      = 1'b0;
    wr_addr     = idx_q;
    held_wdata  = 1'b0;
    cnt_wdata   = '0;
    idx_d       = idx_q;
    ptr_ctrl    = '0;
    case (state_q)
      kpt_pkg::ST_INIT: begin
        held_we = 1'b1;
        cnt_we  = 1'b1;
        idx_d   = idx_last ? '0 : idx_q + 1'b1;
      end
      kpt_pkg::ST_SWEEP: begin
        cnt_we = 1'b1;
        idx_d  = idx_last ? '0 : idx_q + 1'b1;
      end
      kpt_pkg::ST_EXEC: begin
        wr_addr    = addr_q;
        held_wdata = held_new;
        cnt_wdata  = cnt_new;
        held_we    = exec_fire && hit && (is_down || is_up);
        cnt_we     = held_we;
        ptr_ctrl.load_motion = exec_fire && (item_q.action == kpt_pkg::ACT_MOTION);
        ptr_ctrl.add_wheel   = exec_fire && (item_q.action == kpt_pkg::ACT_WHEEL);
        ptr_ctrl.clear_frame = exec_fire && (item_q.action == kpt_pkg::ACT_FRAME_CLEAR);
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (exec_fire) begin
      rsp_valid_d          = 1'b1;
      rsp_d.entry_down     = hit ? held_new : 1'b0;
      rsp_d.entry_presses  = hit ? cnt_new.presses : '0;
      rsp_d.entry_releases = hit ? cnt_new.releases : '0;
      rsp_d.code_ignored   = (is_key || is_button) && !hit;
      rsp_d.pointer_x      = ptr_sum.pointer_x;
      rsp_d.pointer_y      = ptr_sum.pointer_y;
      rsp_d.pointer_dx     = ptr_sum.pointer_dx;
      rsp_d.pointer_dy     = ptr_sum.pointer_dy;
      rsp_d.scroll_left    = ptr_sum.scroll_left;
      rsp_d.scroll_right   = ptr_sum.scroll_right;
      rsp_d.scroll_up      = ptr_sum.scroll_up;
      rsp_d.scroll_down    = ptr_sum.scroll_down;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpt_pkg::ST_INIT;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i.data;
      addr_q <= rd_addr;
    end
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  kpt_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i        (clk_i),
    .rd_en_i      (accept),
    .rd_addr_i    (rd_addr),
    .held_we_i    (held_we),
    .cnt_we_i     (cnt_we),
    .wr_addr_i    (wr_addr),
    .held_wdata_i (held_wdata),
    .cnt_wdata_i  (cnt_wdata),
    .held_rdata_o (held_rdata),
    .cnt_rdata_o  (cnt_rdata)
  );

  kpt_pointer u_pointer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ptr_ctrl),
    .item_i (item_q),
    .sum_o  (ptr_sum)
  );

endmodule
